>>> hdl/ssfh_pkg.sv
// shared types, constants and functions of the spi slave frame engine
`default_nettype none

package ssfh_pkg;

    localparam int FRAME_BYTES        = 4;
    localparam int STATUS_FRAME_BYTES = 7;
    localparam int POS_W              = $clog2(STATUS_FRAME_BYTES + 1);

    localparam logic [7:0] FRAME_PREFIX   = 8'hAA;
    localparam logic [7:0] ACK_BYTE       = 8'h11;
    localparam logic [7:0] IDLE_BYTE      = 8'hFF;
    localparam logic [7:0] LEN_STATUS     = 8'h07;
    localparam logic [7:0] LEN_PLAIN      = 8'h04;
    localparam logic [7:0] STATUS_CODE_RST = 8'h93;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_ACCEPTED    = 4'd1,
        EV_BAD_PREFIX  = 4'd2,
        EV_BAD_CSUM    = 4'd3,
        EV_ACK_OK      = 4'd4,
        EV_ACK_BAD     = 4'd5,
        EV_REPLY_OK    = 4'd6,
        EV_REPLY_BAD   = 4'd7,
        EV_REQ_OK      = 4'd8,
        EV_REQ_DEFER   = 4'd9
    } event_t;

    typedef enum logic {
        OP_EXCHANGE = 1'b0,
        OP_REQUEST  = 1'b1
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] rx_byte;
        logic [7:0] request_value;
        logic [7:0] status_flags;
        logic [7:0] status_layer;
        logic [7:0] battery_level;
    } item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        event_t     event_res;
        logic [7:0] frame_command;
        logic [7:0] frame_value;
        logic       attention;
        logic       sequence_end;
    } result_t;

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

    function automatic logic [7:0] csum3(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2);
        return 8'(popcount8(b0)) + 8'(popcount8(b1)) + 8'(popcount8(b2));
    endfunction

endpackage

`default_nettype wire

>>> hdl/ssfh_core.sv
// frame state machine, byte stores and result logic of the spi slave frame engine
`default_nettype none

module ssfh_core (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     step,
    input  ssfh_pkg::item_t         item,
    input  wire  [7:0]              status_code,
    output ssfh_pkg::result_t       result
);
    import ssfh_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_ACK  = 2'd1,
        MODE_SEQ  = 2'd2
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [1:0]       afi_reg, afi_next;
    logic             sv_reg, sv_next;
    logic [7:0]       rx_store_reg [FRAME_BYTES];
    logic [7:0]       rx_store_next [FRAME_BYTES];
    logic [7:0]       tx_store_reg [STATUS_FRAME_BYTES];
    logic [7:0]       tx_store_next [STATUS_FRAME_BYTES];
    logic [7:0]       sec_reg [STATUS_FRAME_BYTES];
    logic [7:0]       sec_next [STATUS_FRAME_BYTES];
    logic [7:0]       echo_cmd_reg, echo_cmd_next;
    logic [7:0]       echo_val_reg, echo_val_next;

    logic [7:0]       rx_view [FRAME_BYTES];
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] pos_n;
    logic             is_status;
    logic             rx_ok;

    always_comb begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        afi_next      = afi_reg;
        sv_next       = sv_reg;
        rx_store_next = rx_store_reg;
        tx_store_next = tx_store_reg;
        sec_next      = sec_reg;
        echo_cmd_next = echo_cmd_reg;
        echo_val_next = echo_val_reg;
        result        = '0;
        result.event_res = EV_NONE;
        is_status     = 1'b0;
        last_pos      = POS_W'(FRAME_BYTES - 1);
        pos_n         = '0;
        rx_ok         = 1'b0;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            rx_view[i] = rx_store_reg[i];
        end

        if (item.operation == OP_REQUEST) begin
            if (mode_reg != MODE_IDLE) begin
                result.event_res = EV_REQ_DEFER;
            end else begin
                is_status = (item.request_value == status_code);
                sv_next   = is_status;
                for (int i = 0; i < STATUS_FRAME_BYTES; i++) begin
                    tx_store_next[i] = IDLE_BYTE;
                    sec_next[i]      = IDLE_BYTE;
                end
                tx_store_next[0] = FRAME_PREFIX;
                tx_store_next[1] = 8'h00;
                tx_store_next[2] = is_status ? LEN_STATUS : LEN_PLAIN;
                tx_store_next[3] = csum3(FRAME_PREFIX, 8'h00, tx_store_next[2]);
                sec_next[0] = FRAME_PREFIX;
                sec_next[1] = 8'h00;
                sec_next[2] = item.request_value;
                if (is_status) begin
                    sec_next[3] = item.status_flags;
                    sec_next[4] = item.status_layer;
                    sec_next[5] = item.battery_level;
                    sec_next[6] = csum3(FRAME_PREFIX, 8'h00, item.request_value)
                                + csum3(item.status_flags, item.status_layer,
                                        item.battery_level);
                end else begin
                    sec_next[3] = csum3(FRAME_PREFIX, 8'h00, item.request_value);
                end
                mode_next = MODE_SEQ;
                afi_next  = 2'd0;
                pos_next  = '0;
                result.event_res = EV_REQ_OK;
            end
        end else begin
            if (mode_reg == MODE_SEQ && afi_reg == 2'd1 && sv_reg) begin
                last_pos = POS_W'(STATUS_FRAME_BYTES - 1);
            end
            pos_n = (pos_reg > last_pos) ? '0 : pos_reg;
            result.tx_byte = tx_store_reg[pos_n];
            for (int i = 0; i < FRAME_BYTES; i++) begin
                if (pos_n == POS_W'(i)) begin
                    rx_view[i]       = item.rx_byte;
                    rx_store_next[i] = item.rx_byte;
                end
            end
            rx_ok = (rx_view[0] == FRAME_PREFIX)
                 && (rx_view[3] == csum3(rx_view[0], rx_view[1], rx_view[2]));

            if (pos_n == last_pos) begin
                pos_next = '0;
                unique case (mode_reg)
                    MODE_ACK: begin
                        result.frame_command = echo_cmd_reg;
                        result.frame_value   = echo_val_reg;
                        result.event_res = (rx_view[0] == ACK_BYTE && rx_view[1] == ACK_BYTE
                                         && rx_view[2] == ACK_BYTE && rx_view[3] == ACK_BYTE)
                                         ? EV_ACK_OK : EV_ACK_BAD;
                        for (int i = 0; i < STATUS_FRAME_BYTES; i++) begin
                            tx_store_next[i] = IDLE_BYTE;
                        end
                        mode_next = MODE_IDLE;
                    end
                    MODE_SEQ: begin
                        result.frame_command = rx_view[1];
                        result.frame_value   = rx_view[2];
                        result.event_res = rx_ok ? EV_REPLY_OK : EV_REPLY_BAD;
                        if (afi_reg == 2'd0) begin
                            afi_next      = 2'd1;
                            tx_store_next = sec_reg;
                        end else begin
                            for (int i = 0; i < STATUS_FRAME_BYTES; i++) begin
                                tx_store_next[i] = IDLE_BYTE;
                            end
                            if (afi_reg == 2'd1) begin
                                afi_next = 2'd2;
                            end else begin
                                afi_next  = 2'd0;
                                mode_next = MODE_IDLE;
                                result.sequence_end = 1'b1;
                            end
                        end
                    end
                    default: begin
                        result.frame_command = rx_view[1];
                        result.frame_value   = rx_view[2];
                        if (rx_view[0] != FRAME_PREFIX) begin
                            result.event_res = EV_BAD_PREFIX;
                        end else if (!rx_ok) begin
                            result.event_res = EV_BAD_CSUM;
                        end else begin
                            result.event_res = EV_ACCEPTED;
                            echo_cmd_next    = rx_view[1];
                            echo_val_next    = rx_view[2];
                            for (int i = 0; i < STATUS_FRAME_BYTES; i++) begin
                                tx_store_next[i] = (i < FRAME_BYTES) ? rx_view[i % FRAME_BYTES]
                                                                     : IDLE_BYTE;
                            end
                            mode_next = MODE_ACK;
                        end
                    end
                endcase
            end else begin
                pos_next = pos_n + POS_W'(1);
            end
        end
        result.attention = (mode_next == MODE_SEQ);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            pos_reg  <= '0;
            afi_reg  <= '0;
            sv_reg   <= 1'b0;
            for (int i = 0; i < STATUS_FRAME_BYTES; i++) begin
                tx_store_reg[i] <= IDLE_BYTE;
            end
        end else if (step) begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            afi_reg      <= afi_next;
            sv_reg       <= sv_next;
            tx_store_reg <= tx_store_next;
        end
    end

    // stores that are only read after being written
    always_ff @(posedge aclk) begin
        if (step) begin
            rx_store_reg <= rx_store_next;
            sec_reg      <= sec_next;
            echo_cmd_reg <= echo_cmd_next;
            echo_val_reg <= echo_val_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/spi_slave_frame_handshake_unit.sv
// Top level of the spi slave frame engine: input register, core and output register.
//
// One input word per spi byte exchange (tuser = 0) or per active request (tuser = 1).
// Each input word yields exactly one output word: the byte shifted out, an event
// code in tuser, the command and value bytes of a completed frame, the attention
// level, and tlast on the exchange that ends the active three-frame sequence.
// The word sits in the input register and passes the frame logic into the output
// register once that register is empty or its word is being taken.
// Throughput is one word per cycle while m_axis_tready stays high; the frame logic
// is combinational and the state updates as the word leaves the input register.
// When the receiver holds m_axis_tready low the output register keeps its word,
// the input register fills, and s_axis_tready drops until the output drains.
// Reset (aresetn low, synchronous) empties both registers, returns to passive
// idle at byte position zero, fills the transmit bytes with 0xFF and sets the
// status request code to 0x93. The user writes the code through cfg_wr_en/cfg_wr_data
// only while no word is in flight; the block itself does not enforce this.
`default_nettype none

module spi_slave_frame_handshake_unit (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // rx_byte, request_value, status_flags, status_layer, battery_level
    input  wire  [39:0] s_axis_tdata,
    // operation
    input  wire  [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tx_byte, frame_command, frame_value, attention, zero pad
    output logic [31:0] m_axis_tdata,
    // event_res
    output logic [3:0]  m_axis_tuser,
    // sequence_end
    output logic        m_axis_tlast,
    input  wire         cfg_wr_en,
    input  wire  [7:0]  cfg_wr_data
);
    import ssfh_pkg::*;

    logic       in_valid_reg, in_valid_next;
    item_t      in_item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_result_reg;
    result_t    core_result;
    logic [7:0] status_code_reg;
    logic       advance;

    assign advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready  = !in_valid_reg || advance;
    assign in_valid_next  = s_axis_tvalid ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    ssfh_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .item        (in_item_reg),
        .status_code (status_code_reg),
        .result      (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            status_code_reg <= STATUS_CODE_RST;
        end else begin
            if (s_axis_tready) begin
                in_valid_reg <= in_valid_next;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                status_code_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_item_reg.operation     <= op_t'(s_axis_tuser[0]);
            in_item_reg.rx_byte       <= s_axis_tdata[7:0];
            in_item_reg.request_value <= s_axis_tdata[15:8];
            in_item_reg.status_flags  <= s_axis_tdata[23:16];
            in_item_reg.status_layer  <= s_axis_tdata[31:24];
            in_item_reg.battery_level <= s_axis_tdata[39:32];
        end
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_result_reg.attention, out_result_reg.frame_value,
                            out_result_reg.frame_command, out_result_reg.tx_byte};
    assign m_axis_tuser  = out_result_reg.event_res;
    assign m_axis_tlast  = out_result_reg.sequence_end;

endmodule

`default_nettype wire

>>> tb/tb_spi_slave_frame_handshake_unit.sv
// self-checking testbench for the spi slave frame engine with random stream idling
`timescale 1ns / 100ps

module tb_spi_slave_frame_handshake_unit;
    import ssfh_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int PHASES       = 5;
    localparam int PHASE_WORDS  = 400;
    localparam int DRAIN_CYCLES = 6;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_ACK   = 2'd1;
    localparam logic [1:0] MODE_SEQ   = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]      mode;
        logic [2:0]      pos;
        logic [1:0]      frame_idx;
        logic [6:0][7:0] rx_bytes;
        logic [6:0][7:0] tx_bytes;
        logic [6:0][7:0] second_frame;
        logic [3:0][7:0] echo_bytes;
        logic            status_variant;
        logic [7:0]      status_code;
    } engine_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic [0:0]  s_axis_tuser = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [31:0] m_axis_tdata;
    wire  [3:0]  m_axis_tuser;
    wire         m_axis_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    engine_t gen_state;
    engine_t model_state;
    item_t   pending_words[$];
    result_t expected_results[$];
    item_t   held_word;

    int cycles = 0;
    int failures = 0;
    int words_in = 0;
    int results_checked = 0;
    int echoes_done = 0;
    int sequences_done = 0;
    int requests_deferred = 0;
    int frames_rejected = 0;
    int send_gap = 0;
    int send_calm = 0;
    int recv_stall = 0;
    int recv_calm = 0;

    spi_slave_frame_handshake_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [7:0] ones_of(input logic [6:0][7:0] b, input int n);
        logic [7:0] total;
        total = '0;
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < 8; j++) begin
                total = total + 8'(b[i][j]);
            end
        end
        return total;
    endfunction

    function automatic logic [7:0] sum3(input logic [7:0] b0, input logic [7:0] b1,
                                        input logic [7:0] b2);
        return ones_of({32'd0, b2, b1, b0}, 3);
    endfunction

    task automatic reset_engine(output engine_t e);
        e = '0;
        e.mode = MODE_IDLE;
        e.tx_bytes = {7{IDLE_BYTE}};
        e.status_code = STATUS_CODE_RST;
    endtask

    task automatic run_engine(inout engine_t e, input item_t w, output result_t r);
        int len;
        r = '0;
        if (e.mode == MODE_SPARE) begin
            e.mode = MODE_IDLE;
        end
        if (w.operation == OP_REQUEST) begin
            if (e.mode != MODE_IDLE) begin
                r.event_res = EV_REQ_DEFER;
            end else begin
                e.status_variant = (w.request_value == e.status_code);
                e.tx_bytes = {7{IDLE_BYTE}};
                e.tx_bytes[0] = FRAME_PREFIX;
                e.tx_bytes[1] = 8'h00;
                e.tx_bytes[2] = e.status_variant ? LEN_STATUS : LEN_PLAIN;
                e.tx_bytes[3] = ones_of(e.tx_bytes, 3);
                e.second_frame = {7{IDLE_BYTE}};
                e.second_frame[0] = FRAME_PREFIX;
                e.second_frame[1] = 8'h00;
                e.second_frame[2] = w.request_value;
                if (e.status_variant) begin
                    e.second_frame[3] = w.status_flags;
                    e.second_frame[4] = w.status_layer;
                    e.second_frame[5] = w.battery_level;
                    e.second_frame[6] = ones_of(e.second_frame, 6);
                end else begin
                    e.second_frame[3] = ones_of(e.second_frame, 3);
                end
                e.mode = MODE_SEQ;
                e.frame_idx = 2'd0;
                e.pos = 3'd0;
                r.event_res = EV_REQ_OK;
            end
        end else begin
            len = (e.mode == MODE_SEQ && e.frame_idx == 2'd1 && e.status_variant) ?
                  STATUS_FRAME_BYTES : FRAME_BYTES;
            if (e.pos >= len) begin
                e.pos = 3'd0;
            end
            r.tx_byte = e.tx_bytes[e.pos];
            e.rx_bytes[e.pos] = w.rx_byte;
            e.pos = e.pos + 3'd1;
            if (e.pos >= len) begin
                e.pos = 3'd0;
                case (e.mode)
                    MODE_IDLE: begin
                        r.frame_command = e.rx_bytes[1];
                        r.frame_value = e.rx_bytes[2];
                        if (e.rx_bytes[0] != FRAME_PREFIX) begin
                            r.event_res = EV_BAD_PREFIX;
                        end else if (e.rx_bytes[3] != ones_of(e.rx_bytes, 3)) begin
                            r.event_res = EV_BAD_CSUM;
                        end else begin
                            r.event_res = EV_ACCEPTED;
                            e.echo_bytes = e.rx_bytes[3:0];
                            e.tx_bytes = {7{IDLE_BYTE}};
                            e.tx_bytes[3:0] = e.echo_bytes;
                            e.mode = MODE_ACK;
                        end
                    end
                    MODE_ACK: begin
                        r.frame_command = e.echo_bytes[1];
                        r.frame_value = e.echo_bytes[2];
                        r.event_res = (e.rx_bytes[3:0] == {4{ACK_BYTE}}) ? EV_ACK_OK : EV_ACK_BAD;
                        e.tx_bytes = {7{IDLE_BYTE}};
                        e.mode = MODE_IDLE;
                    end
                    default: begin
                        r.frame_command = e.rx_bytes[1];
                        r.frame_value = e.rx_bytes[2];
                        r.event_res = (e.rx_bytes[0] == FRAME_PREFIX &&
                                       e.rx_bytes[3] == ones_of(e.rx_bytes, 3)) ?
                                      EV_REPLY_OK : EV_REPLY_BAD;
                        if (e.frame_idx == 2'd0) begin
                            e.frame_idx = 2'd1;
                            e.tx_bytes = e.second_frame;
                        end else if (e.frame_idx == 2'd1) begin
                            e.frame_idx = 2'd2;
                            e.tx_bytes = {7{IDLE_BYTE}};
                        end else begin
                            e.frame_idx = 2'd0;
                            e.tx_bytes = {7{IDLE_BYTE}};
                            e.mode = MODE_IDLE;
                            r.sequence_end = 1'b1;
                        end
                    end
                endcase
            end
        end
        r.attention = (e.mode == MODE_SEQ);
    endtask

    // stimulus side: queue a word and track where the block will be afterwards
    task automatic push_word(input item_t w);
        result_t unused;
        pending_words.push_back(w);
        run_engine(gen_state, w, unused);
    endtask

    task automatic push_byte(input logic [7:0] b);
        item_t w;
        w = item_t'({$urandom, $urandom});
        w.operation = OP_EXCHANGE;
        w.rx_byte = b;
        push_word(w);
    endtask

    task automatic push_request(input logic [7:0] value);
        item_t w;
        w = item_t'({$urandom, $urandom});
        w.operation = OP_REQUEST;
        w.request_value = value;
        push_word(w);
    endtask

    task automatic push_any_request();
        push_request(($urandom_range(9) < 3) ? gen_state.status_code : 8'($urandom));
    endtask

    // lowest byte goes out first
    task automatic push_run(input logic [6:0][7:0] b, input int n);
        for (int i = 0; i < n; i++) begin
            push_byte(b[i]);
        end
    endtask

    // finish the current frame from the present position, well formed unless corrupted
    task automatic emit_frame(input int len, input int corrupt_pct, input bit ack_pattern);
        logic [6:0][7:0] b;
        int from;
        b = 56'({$urandom, $urandom});
        if (ack_pattern) begin
            b[3:0] = {4{ACK_BYTE}};
        end else begin
            b[0] = FRAME_PREFIX;
            b[3] = sum3(b[0], b[1], b[2]);
        end
        if ($urandom_range(99) < corrupt_pct) begin
            b[$urandom_range(3)][$urandom_range(7)] ^= 1'b1;
        end
        from = (gen_state.pos >= len) ? 0 : int'(gen_state.pos);
        for (int i = from; i < len; i++) begin
            if (gen_state.mode != MODE_IDLE && $urandom_range(99) < 4) begin
                push_any_request();
            end
            push_byte(b[i]);
        end
    endtask

    task automatic pick_gap(inout int calm, output int gap);
        int roll;
        if (calm > 0) begin
            calm--;
            gap = 0;
        end else begin
            roll = $urandom_range(99);
            if (roll < 2) begin
                calm = $urandom_range(80, 30);
            end
            gap = (roll < 60) ? 0 : (roll < 92) ? $urandom_range(3, 1) : $urandom_range(40, 8);
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h actual %0h", name, want, got);
            failures++;
        end
    endtask

    // driver
    always @(posedge aclk) begin
        result_t r;
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                run_engine(model_state, held_word, r);
                expected_results.push_back(r);
                words_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    held_word = pending_words.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {held_word.battery_level, held_word.status_layer,
                                     held_word.status_flags, held_word.request_value,
                                     held_word.rx_byte};
                    s_axis_tuser <= held_word.operation;
                    pick_gap(send_calm, send_gap);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        result_t want;
        int stall;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with no expectation waiting");
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    check_field("tx_byte", want.tx_byte, m_axis_tdata[7:0]);
                    check_field("event_res", 8'(want.event_res), {4'd0, m_axis_tuser});
                    check_field("frame_command", want.frame_command, m_axis_tdata[15:8]);
                    check_field("frame_value", want.frame_value, m_axis_tdata[23:16]);
                    check_field("attention", 8'(want.attention), 8'(m_axis_tdata[24]));
                    check_field("sequence_end", 8'(want.sequence_end), 8'(m_axis_tlast));
                    case (want.event_res)
                        EV_ACK_OK, EV_ACK_BAD:     echoes_done++;
                        EV_REQ_DEFER:              requests_deferred++;
                        EV_BAD_PREFIX, EV_BAD_CSUM: frames_rejected++;
                        default: ;
                    endcase
                    if (want.sequence_end) begin
                        sequences_done++;
                    end
                end
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                pick_gap(recv_calm, stall);
                if (stall > 0) begin
                    recv_stall = stall - 1;
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        logic [7:0] code;
        int phase_end;
        int roll;
        reset_engine(gen_state);
        reset_engine(model_state);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                code = (phase == 1) ? 8'h00 : (phase == 2) ? 8'hFF : 8'($urandom);
                cfg_wr_en <= 1'b1;
                cfg_wr_data <= code;
                @(posedge aclk);
                cfg_wr_en <= 1'b0;
                cfg_wr_data <= 8'($urandom);
                gen_state.status_code = code;
                model_state.status_code = code;
                @(posedge aclk);
            end else begin
                // echo handshake with a request arriving while the ack is pending
                push_run({24'd0, 8'h04, 8'h00, 8'h00, 8'hAA}, 4);
                push_request(8'h00);
                push_run({24'd0, 8'h11, 8'h11, 8'h11, 8'h11}, 4);
                push_run({24'd0, 8'h04, 8'h00, 8'h00, 8'h55}, 4);
                // partial frame cut short by a status request
                push_run({40'd0, 8'hFF, 8'hAA}, 2);
                push_request(STATUS_CODE_RST);
                push_run({24'd0, 8'h07, 8'h07, 8'h00, 8'hAA}, 4);
                push_request(8'hFF);
                push_run({8'd0, 8'hFF, 8'h00, 8'h08, 8'h93, 8'h00, 8'hAA}, 7);
                push_run({24'd0, 8'h00, 8'h00, 8'h00, 8'h00}, 4);
            end

            phase_end = pending_words.size() + words_in + PHASE_WORDS;
            while (pending_words.size() + words_in < phase_end) begin
                roll = $urandom_range(99);
                case (gen_state.mode)
                    MODE_IDLE: begin
                        if (roll < 20) begin
                            push_any_request();
                        end else if (roll < 72) begin
                            emit_frame(FRAME_BYTES, 20, 1'b0);
                        end else if (roll < 88) begin
                            repeat ($urandom_range(3, 1)) push_byte(8'($urandom));
                        end else begin
                            emit_frame(FRAME_BYTES, 0, 1'b1);
                        end
                    end
                    MODE_ACK: begin
                        emit_frame(FRAME_BYTES, 20, (roll >= 10));
                    end
                    default: begin
                        emit_frame((gen_state.frame_idx == 2'd1 && gen_state.status_variant) ?
                                   STATUS_FRAME_BYTES : FRAME_BYTES, 15, 1'b0);
                    end
                endcase
            end

            while (pending_words.size() > 0 || s_axis_tvalid || expected_results.size() > 0) begin
                @(posedge aclk);
            end
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end

        $display("%0d words in, %0d results checked over %0d status code settings",
                 words_in, results_checked, PHASES);
        $display("%0d echoes, %0d active sequences, %0d deferred requests, %0d rejected frames",
                 echoes_done, sequences_done, requests_deferred, frames_rejected);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> spi_slave_frame_handshake_unit.f
hdl/ssfh_pkg.sv
hdl/ssfh_core.sv
hdl/spi_slave_frame_handshake_unit.sv
tb/tb_spi_slave_frame_handshake_unit.sv
